### src/assert_macros.svh
// assertion helpers shared by the decoder modules
// each macro expects signals named clk and rst in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OWSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OWSD_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) trig |=> prop) else $error(msg);
`else
`define OWSD_ASSERT(lbl, prop, msg)
`define OWSD_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

### src/owsd_pkg.sv
package owsd_pkg;

  // sizing
  localparam int DEF_MAX_SENSORS = 16;
  localparam int DIV_STEPS       = 15;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

  // scratchpad layout
  localparam logic [3:0] LAST_POS      = 4'd8;
  localparam logic [7:0] LEGACY_FAMILY = 8'h10;

  // resolution codes in configuration byte bits 6:5
  localparam logic [1:0] RES_9BIT  = 2'b00;
  localparam logic [1:0] RES_10BIT = 2'b01;
  localparam logic [1:0] RES_11BIT = 2'b10;

  // conversion constants
  localparam logic [15:0]        HALF_LSB_OFFSET = 16'd32;
  localparam logic signed [16:0] GLITCH_STEP     = 17'sd10;
  localparam logic [7:0]         CRC_POLY        = 8'h8C;

  // configuration register indexes and reset values
  localparam logic [7:0] CFG_GLITCH_EN  = 8'd0;
  localparam logic [7:0] CFG_CRC_LIMIT  = 8'd1;
  localparam logic [7:0] CRC_LIMIT_RST  = 8'd10;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic div_start;
    logic load_out;
  } owsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_last;
    logic conv_long;
    logic div_busy;
  } owsd_status_t;

  // one byte of the reflected crc-8
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/owsd_div.sv
`include "assert_macros.svh"

module owsd_div
  import owsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [14:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic [14:0] quotient
);

  logic [DIV_CNT_W-1:0] count;
  logic [7:0]           rem;
  logic [7:0]           dvs;
  logic [14:0]          quo;
  logic [8:0]           shifted;
  logic [9:0]           trial;

  // one restoring step per cycle
  assign shifted = {rem, quo[14]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= trial[9] ? shifted[7:0] : trial[7:0];
      quo <= {quo[13:0], ~trial[9]};
    end
  end

  assign quotient = quo;

  `OWSD_ASSERT_NEXT(a_start_busy, start, busy, "divider did not go busy after start")
  `OWSD_ASSERT(a_rem_bound, (busy && dvs != 8'd0) |-> (rem < dvs), "partial remainder out of range")

endmodule

### src/owsd_datapath.sv
`include "assert_macros.svh"

module owsd_datapath
  import owsd_pkg::*;
#(
  parameter int MAX_SENSORS = DEF_MAX_SENSORS
) (
  input  logic         clk,
  input  logic         rst,
  input  owsd_cmd_t    cmd,
  output owsd_status_t status,
  input  logic [7:0]   data_byte,
  input  logic [3:0]   device_index,
  input  logic [7:0]   family_code,
  input  logic         first_of_pass,
  input  logic         glitch_filter_enable,
  input  logic [7:0]   crc_error_limit,
  output logic [15:0]  temperature,
  output logic [3:0]   sensor_index,
  output logic         crc_ok,
  output logic         bus_reset_request
);

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

  logic [3:0]  byte_position;
  logic [7:0]  crc_accumulator;
  logic [7:0]  scratch_store [0:7];
  logic [7:0]  crc_fail_count;
  logic [7:0]  fail_cleared;
  logic [7:0]  fail_next;
  logic        crc_match;

  logic        ok_r;
  logic        legacy_r;
  logic        bus_req_r;
  logic        div_neg;
  logic [3:0]  idx_r;

  logic [15:0]          previous_reading [0:MAX_SENSORS-1];
  logic [MAX_SENSORS-1:0] previous_valid;
  logic [15:0]          prev_rd;

  logic [IDX_W+3:0] rd_ext;
  logic [IDX_W+3:0] wr_ext;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             in_range;

  logic [7:0]  cpc;
  logic [7:0]  cnt_rem;
  logic [8:0]  count_diff;
  logic [7:0]  diff_mag;
  logic        div_busy;
  logic [14:0] quotient;

  logic [15:0] raw;
  logic [15:0] frac_term;
  logic [15:0] legacy_base;
  logic [16:0] step_diff;
  logic        questionable;
  logic        hold_prev;
  logic [15:0] legacy_temp;
  logic [15:0] masked_raw;
  logic [15:0] modern_temp;
  logic        store_reading;

  // byte 8 handling on the accepting transfer
  assign crc_match    = (crc_accumulator == data_byte);
  assign fail_cleared = first_of_pass ? 8'd0 : crc_fail_count;

  always_comb begin
    if (byte_position != LAST_POS) begin
      fail_next = fail_cleared;
    end else if (crc_match) begin
      fail_next = 8'd0;
    end else if (fail_cleared != 8'hFF) begin
      fail_next = fail_cleared + 8'd1;
    end else begin
      fail_next = fail_cleared;
    end
  end

  // status towards the controller
  assign status.pos_last  = (byte_position == LAST_POS);
  assign status.conv_long = crc_match && (family_code == LEGACY_FAMILY);
  assign status.div_busy  = div_busy;

  // position, crc and failure counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_accumulator <= '0;
      crc_fail_count  <= '0;
    end else if (cmd.take_byte) begin
      crc_fail_count <= fail_next;
      if (byte_position == LAST_POS) begin
        byte_position   <= '0;
        crc_accumulator <= '0;
      end else begin
        byte_position   <= byte_position + 4'd1;
        crc_accumulator <= crc8_update(crc_accumulator, data_byte);
      end
    end
  end

  // scratchpad capture and result fields latched on byte 8
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (byte_position != LAST_POS) begin
        scratch_store[byte_position[2:0]] <= data_byte;
      end else begin
        ok_r      <= crc_match;
        legacy_r  <= (family_code == LEGACY_FAMILY);
        idx_r     <= device_index;
        bus_req_r <= (fail_next > crc_error_limit);
      end
    end
  end

  // reading store addressing
  assign rd_ext   = {{IDX_W{1'b0}}, device_index};
  assign wr_ext   = {{IDX_W{1'b0}}, idx_r};
  assign rd_addr  = rd_ext[IDX_W-1:0];
  assign wr_addr  = wr_ext[IDX_W-1:0];
  assign in_range = ({28'd0, idx_r} < 32'(MAX_SENSORS));

  // count register divide, 128 * (cpc - cnt_rem) / cpc
  assign cpc        = scratch_store[7];
  assign cnt_rem    = scratch_store[6];
  assign count_diff = {1'b0, cpc} - {1'b0, cnt_rem};
  assign diff_mag   = count_diff[8] ? 8'(-count_diff) : count_diff[7:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= count_diff[8];
    end
  end

  owsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({diff_mag, 7'd0}),
    .divisor  (cpc),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // extended resolution formula and glitch hold
  assign raw         = {scratch_store[1], scratch_store[0]};
  assign frac_term   = (cpc == 8'd0) ? 16'd0 :
                       (div_neg ? 16'(-{1'b0, quotient}) : {1'b0, quotient});
  assign legacy_base = {raw[9:1], 7'd0} - HALF_LSB_OFFSET + frac_term;
  assign step_diff   = $signed({legacy_base[15], legacy_base}) -
                       $signed({prev_rd[15], prev_rd});
  assign questionable = (cnt_rem == 8'd0) || ($signed(count_diff) <= 9'sd1);
  assign hold_prev   = glitch_filter_enable && in_range && previous_valid[wr_addr] &&
                       questionable && ($signed(step_diff) > GLITCH_STEP);
  assign legacy_temp = hold_prev ? prev_rd : legacy_base;

  // resolution mask for the other families
  always_comb begin
    case (scratch_store[4][6:5])
      RES_9BIT:  masked_raw = raw & 16'hFFF8;
      RES_10BIT: masked_raw = raw & 16'hFFFC;
      RES_11BIT: masked_raw = raw & 16'hFFFE;
      default:   masked_raw = raw;
    endcase
  end
  assign modern_temp = {masked_raw[12:0], 3'd0};

  // previous reading memory, read on every byte, written with the result
  assign store_reading = cmd.load_out && ok_r && legacy_r && in_range;

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      prev_rd <= previous_reading[rd_addr];
    end
    if (store_reading) begin
      previous_reading[wr_addr] <= legacy_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_valid <= '0;
    end else if (store_reading) begin
      previous_valid[wr_addr] <= 1'b1;
    end
  end

  // result fields
  assign temperature       = ok_r ? (legacy_r ? legacy_temp : modern_temp) : 16'd0;
  assign sensor_index      = idx_r;
  assign crc_ok            = ok_r;
  assign bus_reset_request = bus_req_r;

  `OWSD_ASSERT(a_pos_range, byte_position <= LAST_POS, "byte position past end of scratchpad")
  `OWSD_ASSERT_NEXT(a_good_crc_clears, cmd.take_byte && status.pos_last && crc_match,
                    crc_fail_count == 8'd0, "failure count not cleared on good crc")

endmodule

### src/owsd_ctrl.sv
`include "assert_macros.svh"

module owsd_ctrl
  import owsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         out_free,
  input  owsd_status_t status,
  output owsd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // sequencing of bytes, divide and result load
  always_comb begin
    state_next    = state;
    cmd.take_byte = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (status.pos_last) begin
            if (status.conv_long) begin
              cmd.div_start = 1'b1;
              state_next    = ST_DIV;
            end else begin
              state_next = ST_DONE;
            end
          end
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `OWSD_ASSERT(a_load_free, cmd.load_out |-> out_free, "result loaded over an untaken transfer")

endmodule

### src/onewire_scratchpad_temp_decoder_unit.sv
// Scratchpad decoder for 1-Wire temperature sensors. Bytes 0 to 8 of a
// scratchpad arrive as single transfers on the slave side; byte 8 (the CRC)
// produces one result transfer carrying the temperature in 1/128 degree
// units, the device index, the CRC verdict and a bus reset request. Device
// index and family code are taken from the transfer carrying byte 8. Bytes
// 0 to 7 are taken while the controller is idle. For a good 0x10 scratchpad,
// byte 8 also starts the 15-step restoring divider for the count remainder
// term, which a bad CRC or a non-0x10 family skips. After byte 8 the
// slave side stays low on tready until the result is in the output
// register, which frees as soon as the previous result is taken. The
// previous reading of each device lives in a small memory with valid bits
// cleared at reset, so no clearing pass is needed. Configuration writes
// (index 0 glitch filter enable, index 1 crc error limit) are always ready
// and must be issued only while no scratchpad is in progress.
module onewire_scratchpad_temp_decoder_unit
  import owsd_pkg::*;
#(
  parameter int MAX_SENSORS = DEF_MAX_SENSORS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte [7:0], device_index [11:8], family_code [19:12], zero fill
  input  logic [23:0] s_axis_tdata,
  // first_of_pass [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // temperature [15:0], sensor_index [19:16], zero fill
  output logic [23:0] m_axis_tdata,
  // crc_ok [0], bus_reset_request [1]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic         glitch_filter_enable;
  logic [7:0]   crc_error_limit;
  owsd_cmd_t    cmd;
  owsd_status_t status;
  logic         out_free;
  logic [15:0]  temperature;
  logic [3:0]   sensor_index;
  logic         crc_ok;
  logic         bus_reset_request;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_filter_enable <= 1'b0;
      crc_error_limit      <= CRC_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GLITCH_EN: glitch_filter_enable <= cfg_data[0];
        CFG_CRC_LIMIT: crc_error_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  owsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  owsd_datapath #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .data_byte            (s_axis_tdata[7:0]),
    .device_index         (s_axis_tdata[11:8]),
    .family_code          (s_axis_tdata[19:12]),
    .first_of_pass        (s_axis_tuser),
    .glitch_filter_enable (glitch_filter_enable),
    .crc_error_limit      (crc_error_limit),
    .temperature          (temperature),
    .sensor_index         (sensor_index),
    .crc_ok               (crc_ok),
    .bus_reset_request    (bus_reset_request)
  );

  // output register, free when empty or being taken
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= {4'd0, sensor_index, temperature};
      m_axis_tuser <= {bus_reset_request, crc_ok};
    end
  end

endmodule
